/* design/sdq_pkg.sv */
// ============================================================================
// sdq_pkg
// Shared types and constants for the sleep deadline queue: operation and
// result codes, the command passed from front to back, and the control and
// status groups between the sequencer and the sorted entry array.
// ============================================================================
package sdq_pkg;

   // Field widths fixed by the interface.
   localparam int unsigned TICK_W = 48;
   localparam int unsigned ID_W   = 8;
   localparam int unsigned DUR_W  = 32;

   // Largest tick count; both the counter and deadlines saturate here.
   localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

   // At most this many sleepers leave on one tick.
   localparam int unsigned MAX_RESULTS = 16;
   localparam int unsigned REL_CNT_W   = $clog2(MAX_RESULTS + 1);

   // Operation codes of an input transaction.
   localparam logic OP_SLEEP = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   // Result kinds.
   typedef enum logic [1:0] {
      KIND_ACCEPTED  = 2'd0,
      KIND_REJECTED  = 2'd1,
      KIND_RELEASED  = 2'd2,
      KIND_IDLE_TICK = 2'd3
   } sdq_kind_type;

   // Classified command from the front to the back.
   typedef struct packed {
      logic             is_tick;
      logic [ID_W-1:0]  id;
      logic [DUR_W-1:0] dur;
   } sdq_cmd_type;

   // Sequencer requests to the entry array.
   typedef struct packed {
      logic              insert;
      logic              pop;
      logic [TICK_W-1:0] dl;
      logic [ID_W-1:0]   id;
   } sdq_ctrl_type;

   // Entry array status seen by the sequencer.
   typedef struct packed {
      logic              full;
      logic              has_one;
      logic              has_two;
      logic [TICK_W-1:0] head_dl;
      logic [TICK_W-1:0] next_dl;
      logic [ID_W-1:0]   head_id;
   } sdq_stat_type;

endpackage

/* design/sdq_front.sv */
// ============================================================================
// sdq_front
// Accepts request transactions, classifies them into commands and holds
// them in a two-entry queue until the back end takes them.
// ============================================================================
module sdq_front
   import sdq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_operation,
   input  logic [ID_W-1:0]  req_sleeper_id,
   input  logic [DUR_W-1:0] req_duration,
   output logic             cmd_valid,
   output sdq_cmd_type      cmd,
   input  logic             cmd_take
);

   sdq_cmd_type q_ff [2];
   sdq_cmd_type q_in [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   sdq_cmd_type new_cmd;

   // Stall only when both slots hold commands.
   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

   // Classify the incoming transaction.
   always_comb begin
      new_cmd.is_tick = (req_operation == OP_TICK);
      new_cmd.id      = req_sleeper_id;
      new_cmd.dur     = req_duration;
   end

   // Queue pointers and storage.
   always_comb begin
      q_in[0]   = q_ff[0];
      q_in[1]   = q_ff[1];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         q_in[wr_ptr_ff] = new_cmd;
         wr_ptr_in       = !wr_ptr_ff;
      end
      if (cmd_take) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push && !cmd_take) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!push && cmd_take) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

/* design/sdq_array.sv */
// ============================================================================
// sdq_array
// Row of entry cells kept in ascending deadline order. An insert places the
// new sleeper behind all entries due at or before it; a pop shifts the row
// one place toward the head.
// ============================================================================
module sdq_array
   import sdq_pkg::*;
#(
   parameter int unsigned DEPTH = 16
)
(
   input  logic         clock,
   input  logic         reset,
   input  sdq_ctrl_type ctrl,
   output sdq_stat_type stat
);

   localparam int unsigned OCC_W = $clog2(DEPTH + 1);

   logic [TICK_W-1:0] dl_ff [DEPTH];
   logic [TICK_W-1:0] dl_in [DEPTH];
   logic [ID_W-1:0]   id_ff [DEPTH];
   logic [ID_W-1:0]   id_in [DEPTH];
   logic [OCC_W-1:0]  occ_ff, occ_in;
   logic [DEPTH-1:0]  le;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [TICK_W-1:0] up_dl, dn_dl;
      logic [ID_W-1:0]   up_id, dn_id;
      logic              le_prev;

      // An occupied cell that is due no later than the new deadline stays put.
      assign le[i] = (occ_ff > OCC_W'(i)) && (dl_ff[i] <= ctrl.dl);

      // Neighbor values for shifting in either direction.
      if (i == DEPTH - 1) begin : g_top
         assign up_dl = dl_ff[i];
         assign up_id = id_ff[i];
      end else begin : g_mid
         assign up_dl = dl_ff[i+1];
         assign up_id = id_ff[i+1];
      end
      if (i == 0) begin : g_head
         assign dn_dl   = ctrl.dl;
         assign dn_id   = ctrl.id;
         assign le_prev = 1'b1;
      end else begin : g_rest
         assign dn_dl   = dl_ff[i-1];
         assign dn_id   = id_ff[i-1];
         assign le_prev = le[i-1];
      end

      // Next cell contents.
      always_comb begin
         dl_in[i] = dl_ff[i];
         id_in[i] = id_ff[i];
         if (ctrl.pop) begin
            dl_in[i] = up_dl;
            id_in[i] = up_id;
         end else if (ctrl.insert && !le[i]) begin
            if (le_prev) begin
               dl_in[i] = ctrl.dl;
               id_in[i] = ctrl.id;
            end else begin
               dl_in[i] = dn_dl;
               id_in[i] = dn_id;
            end
         end
      end

      always_ff @(posedge clock) begin
         dl_ff[i] <= dl_in[i];
         id_ff[i] <= id_in[i];
      end
   end

   // Occupancy count.
   always_comb begin
      occ_in = occ_ff;
      if (ctrl.insert) begin
         occ_in = occ_ff + OCC_W'(1);
      end else if (ctrl.pop) begin
         occ_in = occ_ff - OCC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   // Status toward the sequencer.
   always_comb begin
      stat.full    = (occ_ff == OCC_W'(DEPTH));
      stat.has_one = (occ_ff != '0);
      stat.has_two = (occ_ff > OCC_W'(1));
      stat.head_dl = dl_ff[0];
      stat.next_dl = dl_ff[1];
      stat.head_id = id_ff[0];
   end

endmodule

/* design/sdq_back.sv */
// ============================================================================
// sdq_back
// Sequencer that carries out commands: it keeps the tick counter, computes
// saturated deadlines, drives inserts and head releases in the entry array,
// and holds the result register.
// ============================================================================
module sdq_back
   import sdq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  sdq_cmd_type       cmd,
   output logic              cmd_take,
   output sdq_ctrl_type      ctrl,
   input  sdq_stat_type      stat,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_kind,
   output logic [ID_W-1:0]   rsp_released_id,
   output logic [TICK_W-1:0] rsp_tick_now,
   output logic              rsp_last
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SLEEP_ADD,
      ST_SLEEP_INS,
      ST_RELEASE
   } state_type;

   state_type            state_ff, state_in;
   logic [TICK_W-1:0]    tick_ff, tick_in;
   logic [REL_CNT_W-1:0] n_ff, n_in;
   logic [TICK_W-1:0]    dl_ff, dl_in;
   logic [ID_W-1:0]      id_ff, id_in;
   logic [DUR_W-1:0]     dur_ff, dur_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   sdq_kind_type         kind_ff, kind_in;
   logic [ID_W-1:0]      rid_ff, rid_in;
   logic [TICK_W-1:0]    rtick_ff, rtick_in;
   logic                 last_ff, last_in;

   logic                 out_free;
   logic                 head_due;
   logic                 next_due;
   logic                 rel_last;
   logic [TICK_W:0]      dl_sum;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign head_due = stat.has_one && (stat.head_dl <= tick_ff);
   assign next_due = stat.has_two && (stat.next_dl <= tick_ff);
   assign rel_last = !next_due || (n_ff == REL_CNT_W'(MAX_RESULTS - 1));
   assign dl_sum   = {1'b0, tick_ff} + (TICK_W + 1)'(dur_ff);

   // Next-state and result logic.
   always_comb begin
      state_in     = state_ff;
      tick_in      = tick_ff;
      n_in         = n_ff;
      dl_in        = dl_ff;
      id_in        = id_ff;
      dur_in       = dur_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in      = kind_ff;
      rid_in       = rid_ff;
      rtick_in     = rtick_ff;
      last_in      = last_ff;
      cmd_take     = 1'b0;
      ctrl.insert  = 1'b0;
      ctrl.pop     = 1'b0;
      ctrl.dl      = dl_ff;
      ctrl.id      = id_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               if (cmd.is_tick) begin
                  tick_in  = (tick_ff == TICK_MAX) ? tick_ff : tick_ff + TICK_W'(1);
                  n_in     = '0;
                  state_in = ST_RELEASE;
               end else begin
                  id_in    = cmd.id;
                  dur_in   = cmd.dur;
                  state_in = ST_SLEEP_ADD;
               end
            end
         end
         ST_SLEEP_ADD: begin
            // Deadline saturates at the counter maximum.
            dl_in    = dl_sum[TICK_W] ? TICK_MAX : dl_sum[TICK_W-1:0];
            state_in = ST_SLEEP_INS;
         end
         ST_SLEEP_INS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rid_in       = '0;
               rtick_in     = tick_ff;
               last_in      = 1'b1;
               if (stat.full) begin
                  kind_in = KIND_REJECTED;
               end else begin
                  ctrl.insert = 1'b1;
                  kind_in     = KIND_ACCEPTED;
               end
               state_in = ST_IDLE;
            end
         end
         ST_RELEASE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rtick_in     = tick_ff;
               if (head_due) begin
                  ctrl.pop = 1'b1;
                  kind_in  = KIND_RELEASED;
                  rid_in   = stat.head_id;
                  last_in  = rel_last;
                  if (rel_last) begin
                     state_in = ST_IDLE;
                  end else begin
                     n_in = n_ff + REL_CNT_W'(1);
                  end
               end else begin
                  // Nothing due on this tick.
                  kind_in  = KIND_IDLE_TICK;
                  rid_in   = '0;
                  last_in  = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      dl_ff    <= dl_in;
      id_ff    <= id_in;
      dur_ff   <= dur_in;
      kind_ff  <= kind_in;
      rid_ff   <= rid_in;
      rtick_ff <= rtick_in;
      last_ff  <= last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= '0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_released_id = rid_ff;
   assign rsp_tick_now    = rtick_ff;
   assign rsp_last        = last_ff;

`ifndef SYNTHESIS
   // The tick counter never moves backward.
   a_tick_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> tick_ff >= $past(tick_ff))
      else $error("tick counter decreased");

   // An insert is never issued into a full array.
   a_no_insert_full: assert property (@(posedge clock) disable iff (reset)
      ctrl.insert |-> !stat.full)
      else $error("insert into full array");

   // A pop only happens when the array holds an entry that is due.
   a_pop_due: assert property (@(posedge clock) disable iff (reset)
      ctrl.pop |-> (stat.has_one && stat.head_dl <= tick_ff))
      else $error("pop without a due head");

   // The release at the per-tick limit always carries the final mark and ends the tick.
   a_release_limit: assert property (@(posedge clock) disable iff (reset)
      (ctrl.pop && n_ff == REL_CNT_W'(MAX_RESULTS - 1)) |=> (last_ff && state_ff == ST_IDLE))
      else $error("release limit exceeded");
`endif

endmodule

/* design/sleep_deadline_queue_unit.sv */
// ============================================================================
// sleep_deadline_queue_unit
// Tick counter with a queue of sleepers sorted by wake deadline.
// ============================================================================
// A sleep transaction passes from acceptance to a valid result through the
// command queue, the deadline add, then the ordered insert into the entry
// row together with the result register; a tick transaction passes through
// the command queue and then gives one result per released sleeper, or an
// idle result, up to sixteen releases per tick. The back-end sequencer
// carries out one command at a time and moves one head entry per cycle. A
// two-entry command queue in front lets requests be accepted while the
// sequencer works. The result register is refilled in the cycle its current
// transaction is taken, so releases leave one per cycle while the output is
// not stalled; a stall holds the sequencer until the result is taken.
// ============================================================================
module sleep_deadline_queue_unit
   import sdq_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 16
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_operation,
   input  logic [ID_W-1:0]   req_sleeper_id,
   input  logic [DUR_W-1:0]  req_duration,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_kind,
   output logic [ID_W-1:0]   rsp_released_id,
   output logic [TICK_W-1:0] rsp_tick_now,
   output logic              rsp_last
);

   logic         cmd_valid;
   sdq_cmd_type  cmd;
   logic         cmd_take;
   sdq_ctrl_type ctrl;
   sdq_stat_type stat;

   // Front end: accepts and classifies transactions.
   sdq_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_sleeper_id (req_sleeper_id),
      .req_duration   (req_duration),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_take       (cmd_take)
   );

   // Sorted entry row.
   sdq_array #(
      .DEPTH (QUEUE_DEPTH)
   ) u_array (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .stat  (stat)
   );

   // Back end: sequencer and result register.
   sdq_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_take        (cmd_take),
      .ctrl            (ctrl),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_released_id (rsp_released_id),
      .rsp_tick_now    (rsp_tick_now),
      .rsp_last        (rsp_last)
   );

endmodule
